[hdl/tmsp_pkg.sv]
// Shared types, constants and helpers for the time spec minutes parser.
// No dependencies; every other file of the block depends on this package.
package tmsp_pkg;

    // Default width of the none word in characters (1..8).
    localparam int NONE_CHARS_DEF = 8;

    localparam int CHAR_W   = 8;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 4;
    localparam int TEXT_W   = 64;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 11'd2047;
    localparam logic [TOTAL_W-1:0] DAY_MINUTES = 11'd1440;
    localparam logic [CNT_W-1:0]   CNT_MAX     = 4'hF;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_UP_H  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6D;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NONE_TEXT   = 1'b0,
        REG_NONE_LENGTH = 1'b1
    } reg_idx_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_EMPTY   = 3'd1,
        STS_CLOCK   = 3'd2,
        STS_SYNTAX  = 3'd3,
        STS_OVER24  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_DIGITS = 3'd1,
        PH_CLOCK  = 3'd2,
        PH_HSUF   = 3'd3,
        PH_MSUF   = 3'd4,
        PH_BAD    = 3'd5
    } phase_t;

    // Per-text parse state
    typedef struct packed {
        phase_t             phase;
        logic [TOTAL_W-1:0] digit_total;
        logic [HOUR_W-1:0]  hour_total;
        logic [CNT_W-1:0]   char_count;
        logic               none_match;
        logic               syntax_bad;
        logic               text_ended;
    } tmsp_state_t;

    localparam tmsp_state_t ST_CLEAR = '{
        phase:       PH_START,
        digit_total: '0,
        hour_total:  '0,
        char_count:  '0,
        none_match:  1'b1,
        syntax_bad:  1'b0,
        text_ended:  1'b0
    };

    function automatic logic is_digit(input logic [CHAR_W-1:0] ch);
        return (ch >= CH_0) && (ch <= CH_9);
    endfunction

    // total * 10 + digit, saturating at 2047
    function automatic logic [TOTAL_W-1:0] push_digit(
        input logic [TOTAL_W-1:0] total,
        input logic [CHAR_W-1:0]  ch
    );
        logic [14:0] t;
        logic [CHAR_W-1:0] d;
        d = ch - CH_0;
        t = {4'b0, total} * 15'd10 + {11'b0, d[3:0]};
        return (t > {4'b0, TOTAL_MAX}) ? TOTAL_MAX : t[TOTAL_W-1:0];
    endfunction

endpackage

[hdl/tmsp_item_if.sv]
// Input channel: one text character per transfer, with end mark and current time.
// Depends on tmsp_pkg.
interface tmsp_item_if;
    logic                            valid;
    logic                            ready;
    logic [tmsp_pkg::CHAR_W-1:0]     character;
    logic                            last;
    logic [tmsp_pkg::HOUR_W-1:0]     now_hour;
    logic [tmsp_pkg::MINUTE_W-1:0]   now_minute;

    modport source (output valid, character, last, now_hour, now_minute, input ready);
    modport sink   (input valid, character, last, now_hour, now_minute, output ready);
endinterface

[hdl/tmsp_result_if.sv]
// Result channel: minutes and status, one transfer per text.
// Depends on tmsp_pkg.
interface tmsp_result_if;
    logic                            valid;
    logic                            ready;
    logic [tmsp_pkg::TOTAL_W-1:0]    minutes;
    logic [tmsp_pkg::STATUS_W-1:0]   status;

    modport source (output valid, minutes, status, input ready);
    modport sink   (input valid, minutes, status, output ready);
endinterface

[hdl/tmsp_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on tmsp_pkg.
interface tmsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tmsp_pkg::CFG_IDX_W-1:0]  index;
    logic [tmsp_pkg::TEXT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tmsp_scan.sv]
// Next parse state for one character: none-word compare, counter, phase walk.
// Depends on tmsp_pkg.
module tmsp_scan #(
    parameter int NONE_CHARS = tmsp_pkg::NONE_CHARS_DEF
) (
    input  tmsp_pkg::tmsp_state_t          cur,
    input  logic [tmsp_pkg::CHAR_W-1:0]    ch,
    input  logic [NONE_CHARS*8-1:0]        none_text,
    input  logic [tmsp_pkg::CNT_W-1:0]     none_length,
    output tmsp_pkg::tmsp_state_t          nxt
);
    import tmsp_pkg::*;

    logic byte_hit;

    always_comb
    begin
        byte_hit = 1'b0;
        for (int i = 0; i < NONE_CHARS; i++)
        begin
            if ((cur.char_count == CNT_W'(i)) && (none_text[i*8 +: 8] == ch))
                byte_hit = 1'b1;
        end
    end

    always_comb
    begin
        nxt = cur;
        if (!cur.text_ended)
        begin
            if (ch == CH_NUL)
            begin
                nxt.text_ended = 1'b1;
            end
            else
            begin
                if (!byte_hit || (cur.char_count >= none_length))
                    nxt.none_match = 1'b0;
                if (cur.char_count != CNT_MAX)
                    nxt.char_count = cur.char_count + CNT_W'(1);

                unique case (cur.phase)
                    PH_START, PH_DIGITS:
                    begin
                        priority if ((ch == CH_PLUS) && (cur.phase == PH_START))
                            nxt.phase = PH_DIGITS;
                        else if (is_digit(ch))
                        begin
                            nxt.digit_total = push_digit(cur.digit_total, ch);
                            nxt.phase       = PH_DIGITS;
                        end
                        else if (ch == CH_COLON)
                        begin
                            nxt.hour_total  = (cur.digit_total > TOTAL_W'(31)) ?
                                              HOUR_W'(31) : cur.digit_total[HOUR_W-1:0];
                            nxt.digit_total = '0;
                            nxt.phase       = PH_CLOCK;
                        end
                        else if ((ch == CH_LO_H) || (ch == CH_UP_H))
                            nxt.phase = PH_HSUF;
                        else if ((ch == CH_LO_M) || (ch == CH_UP_M))
                            nxt.phase = PH_MSUF;
                        else
                        begin
                            nxt.syntax_bad = 1'b1;
                            nxt.phase      = PH_BAD;
                        end
                    end
                    PH_CLOCK:
                    begin
                        if (!cur.syntax_bad)
                        begin
                            if (is_digit(ch))
                                nxt.digit_total = push_digit(cur.digit_total, ch);
                            else
                                nxt.syntax_bad = 1'b1;
                        end
                    end
                    default:
                    begin
                        // suffix already seen, or already bad
                        nxt.syntax_bad = 1'b1;
                        nxt.phase      = PH_BAD;
                    end
                endcase
            end
        end
    end

endmodule

[hdl/tmsp_finish.sv]
// End-of-text evaluation: status precedence and minutes arithmetic.
// Depends on tmsp_pkg.
module tmsp_finish #(
    parameter int NONE_CHARS = tmsp_pkg::NONE_CHARS_DEF
) (
    input  tmsp_pkg::tmsp_state_t          st,
    input  logic [tmsp_pkg::HOUR_W-1:0]    now_hour,
    input  logic [tmsp_pkg::MINUTE_W-1:0]  now_minute,
    input  logic [tmsp_pkg::CNT_W-1:0]     none_length,
    output logic [tmsp_pkg::TOTAL_W-1:0]   minutes,
    output tmsp_pkg::status_t              status
);
    import tmsp_pkg::*;

    logic [12:0]        ahead;
    logic [12:0]        behind;
    logic signed [12:0] d0;
    logic signed [12:0] d1;
    logic signed [12:0] d2;
    logic [16:0]        val;
    logic               none_hit;

    // Clock difference, then wrap into a day (two corrections suffice)
    assign ahead  = {2'b0, st.digit_total} + 13'(st.hour_total) * 13'd60;
    assign behind = 13'(now_hour) * 13'd60 + 13'(now_minute);
    assign d0     = $signed(ahead - behind);
    assign d1     = d0[12] ? d0 + 13'sd1440 : d0;
    assign d2     = d1[12] ? d1 + 13'sd1440 : d1;

    always_comb
    begin
        unique case (st.phase)
            PH_HSUF:  val = 17'(st.digit_total) * 17'd60;
            PH_CLOCK: val = 17'(d2[10:0]);
            default:  val = 17'(st.digit_total);
        endcase
    end

    assign none_hit = (none_length != '0) && (none_length <= CNT_W'(NONE_CHARS)) &&
                      st.none_match && (st.char_count == none_length);

    always_comb
    begin
        priority if (st.char_count == '0)
            status = STS_EMPTY;
        else if (none_hit)
            status = STS_OK;
        else if ((st.phase == PH_CLOCK) &&
                 ((st.hour_total > HOUR_W'(23)) || (st.digit_total > TOTAL_W'(59))))
            status = STS_CLOCK;
        else if (st.syntax_bad)
            status = STS_SYNTAX;
        else if (val > 17'(DAY_MINUTES))
            status = STS_OVER24;
        else
            status = STS_OK;
    end

    assign minutes = ((status == STS_OK) && !none_hit) ? val[TOTAL_W-1:0] : '0;

endmodule

[hdl/time_spec_minutes_parser.sv]
// Top level of the time spec minutes parser: channel registers and parse state.
// Depends on tmsp_pkg, tmsp_item_if, tmsp_result_if, tmsp_cfg_if, tmsp_scan, tmsp_finish.
//
//  Channel | Dir | Fields                                  | Transfer
//  --------+-----+-----------------------------------------+-------------------------
//  item    | in  | character, last, now_hour, now_minute   | valid & ready
//  res     | out | minutes, status                         | valid & ready, one per text
//  cfg     | in  | index (0 none_text, 1 none_length), data| valid & ready, always ready
//
// One character per cycle sustained, unless a final character waits on a stalled
// result. A character is held in the input register; when it leaves, the scan logic
// updates the parse state and, for the final character, the finish logic loads the
// result register; the result port is driven straight from that register.
// Reset clears the channel valids, the parse state and both config registers.
// A stalled result only holds back a final character waiting in the input
// register; earlier characters keep flowing into the parse state.
module time_spec_minutes_parser #(
    parameter int NONE_CHARS = tmsp_pkg::NONE_CHARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    tmsp_item_if.sink      item,
    tmsp_result_if.source  res,
    tmsp_cfg_if.sink       cfg
);
    import tmsp_pkg::*;

    // Configuration
    logic [NONE_CHARS*8-1:0]  none_text_reg;
    logic [CNT_W-1:0]         none_length_reg;

    // Input register
    logic                     in_vld_reg;
    logic [CHAR_W-1:0]        in_char_reg;
    logic                     in_last_reg;
    logic [HOUR_W-1:0]        in_hour_reg;
    logic [MINUTE_W-1:0]      in_minute_reg;

    // Parse state
    tmsp_state_t              state_reg;
    tmsp_state_t              state_scan;
    tmsp_state_t              state_next;

    // Result register
    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic [TOTAL_W-1:0]       out_min_reg;
    status_t                  out_sts_reg;
    logic [TOTAL_W-1:0]       fin_minutes;
    status_t                  fin_status;

    logic                     advance;

    // A held character moves on unless it ends a text and the result slot is full and not being taken
    assign advance    = in_vld_reg && (!in_last_reg || !out_vld_reg || res.ready);
    assign item.ready = !in_vld_reg || advance;
    assign cfg.ready  = 1'b1;

    tmsp_scan #(
        .NONE_CHARS (NONE_CHARS)
    ) u_scan (
        .cur         (state_reg),
        .ch          (in_char_reg),
        .none_text   (none_text_reg),
        .none_length (none_length_reg),
        .nxt         (state_scan)
    );

    tmsp_finish #(
        .NONE_CHARS (NONE_CHARS)
    ) u_finish (
        .st          (state_scan),
        .now_hour    (in_hour_reg),
        .now_minute  (in_minute_reg),
        .none_length (none_length_reg),
        .minutes     (fin_minutes),
        .status      (fin_status)
    );

    // Text state returns to clear after every final character
    always_comb
    begin
        state_next = state_reg;
        if (advance)
            state_next = in_last_reg ? ST_CLEAR : state_scan;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance && in_last_reg)
            out_vld_next = 1'b1;
        else if (res.ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            none_text_reg   <= '0;
            none_length_reg <= '0;
            in_vld_reg      <= 1'b0;
            state_reg       <= ST_CLEAR;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (reg_idx_t'(cfg.index))
                    REG_NONE_TEXT:   none_text_reg   <= cfg.data[NONE_CHARS*8-1:0];
                    REG_NONE_LENGTH: none_length_reg <= cfg.data[CNT_W-1:0];
                    default:         ;
                endcase
            end
            if (item.ready)
                in_vld_reg <= item.valid;
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_char_reg   <= item.character;
            in_last_reg   <= item.last;
            in_hour_reg   <= item.now_hour;
            in_minute_reg <= item.now_minute;
        end
        if (advance && in_last_reg)
        begin
            out_min_reg <= fin_minutes;
            out_sts_reg <= fin_status;
        end
    end

    assign res.valid   = out_vld_reg;
    assign res.minutes = out_min_reg;
    assign res.status  = out_sts_reg;

endmodule

[hdl/tmsp_checker.sv]
// Port-level checks for time_spec_minutes_parser, attached by bind.
// Depends on tmsp_pkg.
module tmsp_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_ready,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [tmsp_pkg::TOTAL_W-1:0]   res_minutes,
    input logic [tmsp_pkg::STATUS_W-1:0]  res_status
);
    import tmsp_pkg::*;

    // Result slot empties on reset
    a_reset_clears: assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // Stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_minutes) && $stable(res_status))
        else $error("stalled result changed");

    // Any failure status carries zero minutes; ok never exceeds a day
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_status == STS_OK) && (res_minutes <= DAY_MINUTES)) ||
                      ((res_status != STS_OK) && (res_minutes == '0)))
        else $error("result minutes inconsistent with status");

    // Input side never stalls while the result slot is empty
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> item_ready)
        else $error("input stalled with empty result slot");

endmodule

bind time_spec_minutes_parser tmsp_checker u_tmsp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_ready  (item.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_minutes (res.minutes),
    .res_status  (res.status)
);
